### rtl/hbfev_pkg.sv
// Harmonic bond force/energy/virial: shared constants, side-band types and
// the output saturation function. No dependencies; compile first.
package hbfev_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_TYPES = 4;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W     = 32;
  localparam int TYPE_W    = 2;
  localparam int ENERGY_W  = 47;
  localparam int OUT_W     = 48;

  // register map
  localparam int REG_STIFF_BASE = 0;
  localparam int REG_REST_BASE  = NUM_TYPES;

  localparam int TIDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

  // datapath widths
  localparam int DMW   = POS_W;            // |b - a| < 2^32
  localparam int SUMW  = 2 * DMW + 2;      // sum of three squares
  localparam int RW    = SUMW / 2;         // root width
  localparam int EMW   = RW;               // |r - l0|
  localparam int KEW   = CFG_W + EMW;      // k * |e|
  localparam int KELO  = (KEW + 1) / 2;
  localparam int KEHI  = KEW - KELO;
  localparam int NUMW  = KEW + DMW;        // k * |e| * |d_j|
  localparam int DVDW  = NUMW - FRAC_BITS; // dividend after dropping fraction
  localparam int QW    = KEW - FRAC_BITS;  // |d_j| <= r bounds the quotient
  localparam int QLO   = (QW + 1) / 2;
  localparam int QHI   = QW - QLO;
  localparam int ESQW  = 2 * EMW;
  localparam int ESQLO = ESQW / 2;
  localparam int ETW   = ESQW + CFG_W;
  localparam int ESH   = 2 * FRAC_BITS + 1;
  localparam int VTW   = DMW + QW;
  localparam int SATW  = VTW;

  localparam int DIV_LANES = 3;
  localparam int NUM_VIR   = 6;

  localparam int VIR_I [NUM_VIR] = '{0, 0, 0, 1, 1, 2};
  localparam int VIR_J [NUM_VIR] = '{0, 1, 2, 1, 2, 2};

  typedef struct packed {
    logic [2:0][DMW-1:0] dm;
    logic [2:0]          dn;
    logic [CFG_W-1:0]    k;
    logic [CFG_W-1:0]    l0;
    logic                eob;
  } sq_side_t;

  typedef struct packed {
    logic [2:0][DMW-1:0]   dm;
    logic [2:0]            dn;
    logic                  eneg;
    logic                  zero;
    logic [ENERGY_W-1:0]   energy;
    logic                  eob;
  } div_side_t;

  // sign-magnitude to saturated two's complement
  function automatic logic [OUT_W-1:0] sat_out(input logic neg, input logic [SATW-1:0] mag);
    logic [SATW-1:0] lim;
    logic [SATW-1:0] m;
    lim = neg ? (SATW'(1) << (OUT_W - 1)) : ((SATW'(1) << (OUT_W - 1)) - SATW'(1));
    m   = (mag > lim) ? lim : mag;
    return neg ? (~m[OUT_W-1:0] + OUT_W'(1)) : m[OUT_W-1:0];
  endfunction

endpackage

### rtl/hbfev_if.sv
// Bond and result channel interfaces (valid/ready plus payload).
// Depends on hbfev_pkg.
interface hbfev_in_if;
  import hbfev_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  a_x;
  logic signed [POS_W-1:0]  a_y;
  logic signed [POS_W-1:0]  a_z;
  logic signed [POS_W-1:0]  b_x;
  logic signed [POS_W-1:0]  b_y;
  logic signed [POS_W-1:0]  b_z;
  logic [TYPE_W-1:0]        bond_type;
  logic                     end_of_batch;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, bond_type, end_of_batch,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, bond_type, end_of_batch,
                output ready);
endinterface

interface hbfev_out_if;
  import hbfev_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ENERGY_W-1:0]      energy;
  logic signed [OUT_W-1:0]  force_x;
  logic signed [OUT_W-1:0]  force_y;
  logic signed [OUT_W-1:0]  force_z;
  logic signed [OUT_W-1:0]  virial_xx;
  logic signed [OUT_W-1:0]  virial_xy;
  logic signed [OUT_W-1:0]  virial_xz;
  logic signed [OUT_W-1:0]  virial_yy;
  logic signed [OUT_W-1:0]  virial_yz;
  logic signed [OUT_W-1:0]  virial_zz;
  logic                     zero_length;
  logic                     batch_done;

  modport source (output valid, energy, force_x, force_y, force_z, virial_xx, virial_xy,
                  virial_xz, virial_yy, virial_yz, virial_zz, zero_length, batch_done,
                  input ready);
  modport sink (input valid, energy, force_x, force_y, force_z, virial_xx, virial_xy,
                virial_xz, virial_yy, virial_yz, virial_zz, zero_length, batch_done,
                output ready);
endinterface

### rtl/harmonic_bond_force_energy_virial.sv
// Harmonic bond energy, force and virial tensor, fully pipelined.
// Depends on hbfev_pkg, hbfev_if, hbfev_isqrt and hbfev_div.
//
// Use:
//  - in_if carries one bond per item: endpoints a and b (signed Q16.16) and a
//    bond type selecting stiffness k and rest length l0.
//  - out_if returns one result item per bond, in order: energy, force on a,
//    the six tensor components d_i*F_j, zero_length and batch_done.
//  - cfg_we_i/cfg_idx_i/cfg_data_i write the registers: index 0..3 are the
//    stiffnesses, 4..7 the rest lengths. Write only while the pipe is empty.
// Throughput: one item per cycle unless stalled. Registers from acceptance
//   to out_if.valid, in order: P1..P3, RW = 33 square-root stages (one root
//   bit each), P4..P7, QW = 65 - FRAC_BITS divider stages (one quotient bit
//   each), P8 and the output register; the divider sets most of the depth.
// Stall: the whole pipe advances only when the output register is empty or
//   taken, so in_if.ready = !out_if.valid || out_if.ready. Bubbles hold still
//   under stall; nothing is dropped or duplicated.
// Reset: all valid bits clear and the configuration registers go to 0.
module harmonic_bond_force_energy_virial (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hbfev_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hbfev_pkg::CFG_W-1:0]   cfg_data_i,
  hbfev_in_if.sink                      in_if,
  hbfev_out_if.source                   out_if
);
  import hbfev_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] k_q  [NUM_TYPES];
  logic [CFG_W-1:0] l0_q [NUM_TYPES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < NUM_TYPES; t++) begin
        k_q[t]  <= '0;
        l0_q[t] <= '0;
      end
    end else if (cfg_we_i) begin
      for (int t = 0; t < NUM_TYPES; t++) begin
        if (cfg_idx_i == CFG_IDX_W'(REG_STIFF_BASE + t)) k_q[t]  <= cfg_data_i;
        if (cfg_idx_i == CFG_IDX_W'(REG_REST_BASE + t))  l0_q[t] <= cfg_data_i;
      end
    end
  end

  // global advance: output register free or being taken
  logic en;
  logic out_vld_q;
  assign en          = !out_vld_q || out_if.ready;
  assign in_if.ready = en;

  // ---------------------------------------------------------------------
  // P1: difference vector, magnitude/sign, register select
  // ---------------------------------------------------------------------
  logic     p1_vld_q;
  sq_side_t p1_side_q, p1_side_d;

  always_comb begin
    logic [2:0][POS_W-1:0] pa;
    logic [2:0][POS_W-1:0] pb;
    logic [DMW:0]          dif;
    logic [TIDX_W-1:0]     tsel;
    pa = {in_if.a_z, in_if.a_y, in_if.a_x};
    pb = {in_if.b_z, in_if.b_y, in_if.b_x};
    // out-of-range types clamp to the last one
    if (int'(in_if.bond_type) >= NUM_TYPES) tsel = TIDX_W'(NUM_TYPES - 1);
    else                                    tsel = TIDX_W'(in_if.bond_type);
    for (int i = 0; i < 3; i++) begin
      dif = {pb[i][POS_W-1], pb[i]} - {pa[i][POS_W-1], pa[i]};
      p1_side_d.dn[i] = dif[DMW];
      p1_side_d.dm[i] = dif[DMW] ? DMW'(-dif) : dif[DMW-1:0];
    end
    p1_side_d.k   = k_q[tsel];
    p1_side_d.l0  = l0_q[tsel];
    p1_side_d.eob = in_if.end_of_batch;
  end

  // ---------------------------------------------------------------------
  // P2: squares, P3: sum of squares
  // ---------------------------------------------------------------------
  logic                  p2_vld_q, p3_vld_q;
  logic [2:0][2*DMW-1:0] p2_sq_q;
  sq_side_t              p2_side_q, p3_side_q;
  logic [SUMW-1:0]       p3_sum_q;

  // ---------------------------------------------------------------------
  // Square root (RW stages)
  // ---------------------------------------------------------------------
  logic          sq_vld;
  logic [RW-1:0] sq_root;
  sq_side_t      sq_side;

  hbfev_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p3_vld_q),
    .rad_i   (p3_sum_q),
    .side_i  (p3_side_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // ---------------------------------------------------------------------
  // P4: e = r - l0; P5: e^2 and k*|e|; P6: partial products; P7: combine
  // ---------------------------------------------------------------------
  logic           p4_vld_q, p5_vld_q, p6_vld_q, p7_vld_q;
  sq_side_t       p4_side_q, p5_side_q, p6_side_q;
  logic [RW-1:0]  p4_r_q, p5_r_q, p6_r_q, p7_r_q;
  logic [EMW-1:0] p4_em_q;
  logic           p4_eneg_q, p5_eneg_q, p6_eneg_q;
  logic           p4_zero_q, p5_zero_q, p6_zero_q;
  logic [EMW-1:0] p4_em_d;
  logic           p4_eneg_d;

  logic [ESQW-1:0] p5_esq_q;
  logic [KEW-1:0]  p5_ke_q;

  logic [ESQLO+CFG_W-1:0]        p6_epl_q;
  logic [ESQW-ESQLO+CFG_W-1:0]   p6_eph_q;
  logic [2:0][KELO+DMW-1:0]      p6_fpl_q;
  logic [2:0][KEHI+DMW-1:0]      p6_fph_q;

  logic [DIV_LANES-1:0][DVDW-1:0] p7_dvd_q, p7_dvd_d;
  div_side_t                      p7_dside_q, p7_dside_d;

  always_comb begin
    logic [EMW:0] ediff;
    ediff     = {1'b0, sq_root} - (EMW + 1)'(sq_side.l0);
    p4_eneg_d = ediff[EMW];
    p4_em_d   = ediff[EMW] ? EMW'(-ediff) : ediff[EMW-1:0];
  end

  always_comb begin
    logic [ETW-1:0]  etot;
    logic [ETW-1:0]  esh;
    logic [NUMW-1:0] num;
    etot = (ETW'(p6_eph_q) << ESQLO) + ETW'(p6_epl_q);
    esh  = etot >> ESH;
    p7_dside_d.energy = (|esh[ETW-1:ENERGY_W]) ? {ENERGY_W{1'b1}} : esh[ENERGY_W-1:0];
    for (int j = 0; j < DIV_LANES; j++) begin
      num = (NUMW'(p6_fph_q[j]) << KELO) + NUMW'(p6_fpl_q[j]);
      p7_dvd_d[j] = num[NUMW-1:FRAC_BITS];
    end
    p7_dside_d.dm   = p6_side_q.dm;
    p7_dside_d.dn   = p6_side_q.dn;
    p7_dside_d.eneg = p6_eneg_q;
    p7_dside_d.zero = p6_zero_q;
    p7_dside_d.eob  = p6_side_q.eob;
  end

  // ---------------------------------------------------------------------
  // Division by r (QW stages)
  // ---------------------------------------------------------------------
  logic                         dv_vld;
  logic [DIV_LANES-1:0][QW-1:0] dv_quo;
  div_side_t                    dv_side;

  hbfev_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p7_vld_q),
    .dvs_i   (p7_r_q),
    .dvd_i   (p7_dvd_q),
    .side_i  (p7_dside_q),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // ---------------------------------------------------------------------
  // P8: force saturation and tensor partial products
  // ---------------------------------------------------------------------
  logic                          p8_vld_q;
  logic [2:0][OUT_W-1:0]         p8_force_q, p8_force_d;
  logic [2:0]                    p8_fneg_q, p8_fneg_d;
  logic [NUM_VIR-1:0][DMW+QLO-1:0] p8_vpl_q, p8_vpl_d;
  logic [NUM_VIR-1:0][DMW+QHI-1:0] p8_vph_q, p8_vph_d;
  div_side_t                     p8_side_q;

  always_comb begin
    logic [2:0][QW-1:0] fm;
    for (int j = 0; j < 3; j++) begin
      fm[j]         = dv_side.zero ? '0 : dv_quo[j];
      p8_fneg_d[j]  = (fm[j] != '0) && (dv_side.eneg != dv_side.dn[j]);
      p8_force_d[j] = sat_out(p8_fneg_d[j], SATW'(fm[j]));
    end
    for (int o = 0; o < NUM_VIR; o++) begin
      p8_vpl_d[o] = dv_side.dm[VIR_I[o]] * fm[VIR_J[o]][QLO-1:0];
      p8_vph_d[o] = dv_side.dm[VIR_I[o]] * fm[VIR_J[o]][QW-1:QLO];
    end
  end

  // ---------------------------------------------------------------------
  // P9: output register
  // ---------------------------------------------------------------------
  logic [ENERGY_W-1:0]           out_energy_q;
  logic [2:0][OUT_W-1:0]         out_force_q;
  logic [NUM_VIR-1:0][OUT_W-1:0] out_vir_q, out_vir_d;
  logic                          out_zero_q, out_eob_q;

  always_comb begin
    logic [VTW-1:0] t;
    logic           vneg;
    for (int o = 0; o < NUM_VIR; o++) begin
      t    = ((VTW'(p8_vph_q[o]) << QLO) + VTW'(p8_vpl_q[o])) >> FRAC_BITS;
      vneg = (t != '0) && (p8_side_q.dn[VIR_I[o]] != p8_fneg_q[VIR_J[o]]);
      out_vir_d[o] = sat_out(vneg, SATW'(t));
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p3_vld_q  <= 1'b0;
      p4_vld_q  <= 1'b0;
      p5_vld_q  <= 1'b0;
      p6_vld_q  <= 1'b0;
      p7_vld_q  <= 1'b0;
      p8_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q  <= in_if.valid;
      p2_vld_q  <= p1_vld_q;
      p3_vld_q  <= p2_vld_q;
      p4_vld_q  <= sq_vld;
      p5_vld_q  <= p4_vld_q;
      p6_vld_q  <= p5_vld_q;
      p7_vld_q  <= p6_vld_q;
      p8_vld_q  <= dv_vld;
      out_vld_q <= p8_vld_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_side_q <= p1_side_d;

      for (int i = 0; i < 3; i++) begin
        p2_sq_q[i] <= p1_side_q.dm[i] * p1_side_q.dm[i];
      end
      p2_side_q <= p1_side_q;

      p3_sum_q  <= SUMW'(p2_sq_q[0]) + SUMW'(p2_sq_q[1]) + SUMW'(p2_sq_q[2]);
      p3_side_q <= p2_side_q;

      p4_side_q <= sq_side;
      p4_r_q    <= sq_root;
      p4_em_q   <= p4_em_d;
      p4_eneg_q <= p4_eneg_d;
      p4_zero_q <= (sq_root == '0);

      p5_esq_q  <= p4_em_q * p4_em_q;
      p5_ke_q   <= p4_side_q.k * p4_em_q;
      p5_side_q <= p4_side_q;
      p5_r_q    <= p4_r_q;
      p5_eneg_q <= p4_eneg_q;
      p5_zero_q <= p4_zero_q;

      p6_epl_q <= p5_esq_q[ESQLO-1:0] * p5_side_q.k;
      p6_eph_q <= p5_esq_q[ESQW-1:ESQLO] * p5_side_q.k;
      for (int j = 0; j < 3; j++) begin
        p6_fpl_q[j] <= p5_ke_q[KELO-1:0] * p5_side_q.dm[j];
        p6_fph_q[j] <= p5_ke_q[KEW-1:KELO] * p5_side_q.dm[j];
      end
      p6_side_q <= p5_side_q;
      p6_r_q    <= p5_r_q;
      p6_eneg_q <= p5_eneg_q;
      p6_zero_q <= p5_zero_q;

      p7_dvd_q   <= p7_dvd_d;
      p7_dside_q <= p7_dside_d;
      p7_r_q     <= p6_r_q;

      p8_force_q <= p8_force_d;
      p8_fneg_q  <= p8_fneg_d;
      p8_vpl_q   <= p8_vpl_d;
      p8_vph_q   <= p8_vph_d;
      p8_side_q  <= dv_side;

      out_energy_q <= p8_side_q.energy;
      out_force_q  <= p8_force_q;
      out_vir_q    <= out_vir_d;
      out_zero_q   <= p8_side_q.zero;
      out_eob_q    <= p8_side_q.eob;
    end
  end

  assign out_if.valid       = out_vld_q;
  assign out_if.energy      = out_energy_q;
  assign out_if.force_x     = out_force_q[0];
  assign out_if.force_y     = out_force_q[1];
  assign out_if.force_z     = out_force_q[2];
  assign out_if.virial_xx   = out_vir_q[0];
  assign out_if.virial_xy   = out_vir_q[1];
  assign out_if.virial_xz   = out_vir_q[2];
  assign out_if.virial_yy   = out_vir_q[3];
  assign out_if.virial_yz   = out_vir_q[4];
  assign out_if.virial_zz   = out_vir_q[5];
  assign out_if.zero_length = out_zero_q;
  assign out_if.batch_done  = out_eob_q;

`ifndef SYNTHESIS
  // root is zero exactly when the endpoints coincide
  a_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld |-> ((sq_root == '0) == (sq_side.dm == '0)))
    else $error("root zero mismatch with difference vector");

  // coincident endpoints give no force and no tensor
  a_zero_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_zero_q) |-> (out_force_q == '0 && out_vir_q == '0))
    else $error("zero-length bond with nonzero force or tensor");

  // diagonal components never have opposite signs (all follow the sign of r - l0)
  a_diag_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !((out_vir_q[0][OUT_W-1] || out_vir_q[3][OUT_W-1] ||
                     out_vir_q[5][OUT_W-1]) &&
                    ((!out_vir_q[0][OUT_W-1] && out_vir_q[0] != '0) ||
                     (!out_vir_q[3][OUT_W-1] && out_vir_q[3] != '0) ||
                     (!out_vir_q[5][OUT_W-1] && out_vir_q[5] != '0))))
    else $error("diagonal tensor components of opposite sign");

  // output valid only moves when the pipe advances
  a_valid_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(out_vld_q) |-> $past(en))
    else $error("output valid changed during stall");
`endif

endmodule

### rtl/hbfev_isqrt.sv
// Pipelined integer square root, one root bit per stage, side band carried.
// Depends on hbfev_pkg.
module hbfev_isqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [hbfev_pkg::SUMW-1:0] rad_i,
  input  hbfev_pkg::sq_side_t      side_i,
  output logic                     valid_o,
  output logic [hbfev_pkg::RW-1:0] root_o,
  output hbfev_pkg::sq_side_t      side_o
);
  import hbfev_pkg::*;

  localparam int REMW = RW + 2;

  logic [RW-1:0]   vld_q, vld_d;
  logic [SUMW-1:0] rad_q  [RW];
  logic [SUMW-1:0] rad_d  [RW];
  logic [REMW-1:0] rem_q  [RW];
  logic [REMW-1:0] rem_d  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [RW-1:0]   root_d [RW];
  sq_side_t        side_q [RW];
  sq_side_t        side_d [RW];

  always_comb begin
    logic [SUMW-1:0] rad;
    logic [REMW-1:0] rem;
    logic [RW-1:0]   root;
    logic [REMW+1:0] rem2;
    logic [REMW+1:0] trial;
    for (int s = 0; s < RW; s++) begin
      if (s == 0) begin
        vld_d[s]  = valid_i;
        rad       = rad_i;
        rem       = '0;
        root      = '0;
        side_d[s] = side_i;
      end else begin
        vld_d[s]  = vld_q[s-1];
        rad       = rad_q[s-1];
        rem       = rem_q[s-1];
        root      = root_q[s-1];
        side_d[s] = side_q[s-1];
      end
      rem2  = {rem, rad[SUMW-1 -: 2]};
      trial = {2'b00, root, 2'b01};
      if (rem2 >= trial) begin
        rem_d[s]  = REMW'(rem2 - trial);
        root_d[s] = {root[RW-2:0], 1'b1};
      end else begin
        rem_d[s]  = REMW'(rem2);
        root_d[s] = {root[RW-2:0], 1'b0};
      end
      rad_d[s] = {rad[SUMW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < RW; s++) begin
        rad_q[s]  <= rad_d[s];
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
        side_q[s] <= side_d[s];
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

### rtl/hbfev_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient
// bit per stage. Depends on hbfev_pkg.
module hbfev_div (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           en_i,
  input  logic                                           valid_i,
  input  logic [hbfev_pkg::RW-1:0]                       dvs_i,
  input  logic [hbfev_pkg::DIV_LANES-1:0][hbfev_pkg::DVDW-1:0] dvd_i,
  input  hbfev_pkg::div_side_t                           side_i,
  output logic                                           valid_o,
  output logic [hbfev_pkg::DIV_LANES-1:0][hbfev_pkg::QW-1:0]   quo_o,
  output hbfev_pkg::div_side_t                           side_o
);
  import hbfev_pkg::*;

  logic [QW-1:0] vld_q, vld_d;
  logic [RW-1:0] dvs_q  [QW];
  logic [RW-1:0] dvs_d  [QW];
  logic [RW-1:0] rem_q  [QW][DIV_LANES];
  logic [RW-1:0] rem_d  [QW][DIV_LANES];
  logic [QW-1:0] lo_q   [QW][DIV_LANES];
  logic [QW-1:0] lo_d   [QW][DIV_LANES];
  div_side_t     side_q [QW];
  div_side_t     side_d [QW];

  always_comb begin
    logic [RW-1:0] dvs;
    logic [RW-1:0] rem;
    logic [QW-1:0] lo;
    logic [RW:0]   rem2;
    logic          qb;
    for (int s = 0; s < QW; s++) begin
      if (s == 0) begin
        vld_d[s]  = valid_i;
        dvs       = dvs_i;
        side_d[s] = side_i;
      end else begin
        vld_d[s]  = vld_q[s-1];
        dvs       = dvs_q[s-1];
        side_d[s] = side_q[s-1];
      end
      dvs_d[s] = dvs;
      for (int l = 0; l < DIV_LANES; l++) begin
        if (s == 0) begin
          // upper dividend bits are below the divisor, so QW bits of quotient suffice
          rem = RW'(dvd_i[l][DVDW-1:QW]);
          lo  = dvd_i[l][QW-1:0];
        end else begin
          rem = rem_q[s-1][l];
          lo  = lo_q[s-1][l];
        end
        rem2 = {rem, lo[QW-1]};
        qb   = (rem2 >= {1'b0, dvs});
        rem_d[s][l] = qb ? RW'(rem2 - {1'b0, dvs}) : RW'(rem2);
        lo_d[s][l]  = {lo[QW-2:0], qb};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QW; s++) begin
        dvs_q[s]  <= dvs_d[s];
        side_q[s] <= side_d[s];
        for (int l = 0; l < DIV_LANES; l++) begin
          rem_q[s][l] <= rem_d[s][l];
          lo_q[s][l]  <= lo_d[s][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < DIV_LANES; l++) begin
      quo_o[l] = lo_q[QW-1][l];
    end
  end

  assign valid_o = vld_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule
